// ===== rtl/kpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpp_pkg
// Shared widths, codes and transfer records for the k-means++ seeding block.
// ----------------------------------------------------------------------------
package kpp_pkg;

  // Field widths of the stream items
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int COORD_W  = 16;
  localparam int RAND_W   = 16;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int PCNT_W   = 11;
  localparam int CCNT_W   = 7;

  // Nearest squared distance: two squares of a (COORD_W+1)-bit difference
  localparam int NEAR_W = 2 * COORD_W + 1;
  localparam logic [NEAR_W-1:0] NEAR_FAR = '1;

  // Defaults for the top-level parameters
  localparam int MAX_POINTS_DEF  = 1024;
  localparam int MAX_CENTERS_DEF = 64;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PLACED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_POINTS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALL_DONE  = 2'd2;

  // Register indexes
  localparam logic REG_POINT_COUNT  = 1'b0;
  localparam logic REG_CENTER_COUNT = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] point_index;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               point_deleted;
    logic [RAND_W-1:0]  random_word;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   center_slot;
    logic [COORD_W-1:0]  center_x;
    logic [COORD_W-1:0]  center_y;
    logic [INDEX_W-1:0]  chosen_point;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/kmeans_plus_plus_seeding_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmeans_plus_plus_seeding_top
// k-means++ seeding of 2-D centers over a stored point set.
//
//   channel   dir   payload
//   s_*       in    command: load point / pick first / pick next
//   m_*       out   placed center and status
//   p*        cfg   point_count (0x0), center_count (0x4)
//
// A load writes the point memory. Pick first runs the remainder unit, then one
// nearest-memory write per entry. Pick next makes two walks over the n points
// through the memory read port. Reset is synchronous; the stores are not
// cleared. A waiting result in the output register does not block the next
// command.
// ----------------------------------------------------------------------------
module kmeans_plus_plus_seeding_top import kpp_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int MAX_CENTERS = MAX_CENTERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [9:0] point_index, [25:10] point_x, [41:26] point_y, [42] point_deleted,
  // [58:43] random_word, rest zero
  input  wire logic [63:0] s_tdata,
  // [1:0] kind
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [5:0] center_slot, [21:6] center_x, [37:22] center_y, [47:38] chosen_point
  output logic [47:0]      m_tdata,
  // [1:0] status
  output logic [1:0]       m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [PCNT_W-1:0] point_count;
  logic [CCNT_W-1:0] center_count;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= '0;
      center_count <= CCNT_W'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_POINT_COUNT) begin
        point_count <= pwdata[PCNT_W-1:0];
      end else begin
        center_count <= pwdata[CCNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_CENTER_COUNT) ? 32'(center_count) : 32'(point_count);

  // command unpack
  cmd_t cmd;

  always_comb begin
    cmd.kind          = s_tuser;
    cmd.point_index   = s_tdata[9:0];
    cmd.point_x       = s_tdata[25:10];
    cmd.point_y       = s_tdata[41:26];
    cmd.point_deleted = s_tdata[42];
    cmd.random_word   = s_tdata[58:43];
  end

  logic    res_valid, res_ready;
  result_t res, out_r;

  kpp_engine #(.MAX_POINTS(MAX_POINTS), .MAX_CENTERS(MAX_CENTERS)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (s_tvalid),
    .cmd_ready    (s_tready),
    .cmd          (cmd),
    .point_count  (point_count),
    .center_count (center_count),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign m_tdata = {out_r.chosen_point, out_r.center_y, out_r.center_x, out_r.center_slot};
  assign m_tuser = out_r.status;

endmodule
`default_nettype wire

// ===== rtl/kpp_mod_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpp_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module kpp_mod_unit #(
  parameter int DW = 16,
  parameter int VW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [VW-1:0]      rem
);

  localparam int SW = $clog2(DW + 1);

  logic          busy;
  logic [SW-1:0] steps;
  logic [DW-1:0] quo;
  logic [VW:0]   trial;

  assign trial = {rem, quo[DW-1]};

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
        quo   <= dividend;
        rem   <= '0;
      end else if (busy) begin
        quo <= quo << 1;
        if (trial >= {1'b0, divisor}) begin
          rem <= VW'(trial - {1'b0, divisor});
        end else begin
          rem <= VW'(trial);
        end
        steps <= steps + 1'b1;
        if (steps == SW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kpp_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpp_engine
// Point and nearest-distance memories with the seeding sequencer.
// ----------------------------------------------------------------------------
module kpp_engine import kpp_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int MAX_CENTERS = MAX_CENTERS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire cmd_t              cmd,
  input  wire logic [PCNT_W-1:0] point_count,
  input  wire logic [CCNT_W-1:0] center_count,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output result_t                res
);

  localparam int IW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int PCW = $clog2(MAX_CENTERS + 1);
  localparam int TW  = NEAR_W + CW;
  localparam int LO  = TW / 2;
  localparam int HI  = TW - LO;
  localparam int TGW = TW + RAND_W;
  localparam int PW  = 2 * COORD_W + 1;
  localparam int SQW = 2 * COORD_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_CLEAR, S_P1, S_MUL0, S_MUL1, S_MUL2, S_P2,
    S_FETCH, S_FETCH2, S_DONE
  } state_t;

  state_t state;

  // effective counts
  logic [CW-1:0]  n_eff;
  logic [PCW-1:0] wanted;

  always_comb begin
    n_eff  = (32'(point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(point_count);
    wanted = (32'(center_count) > 32'(MAX_CENTERS)) ? PCW'(MAX_CENTERS)
                                                      : PCW'(center_count);
  end

  // point memory {deleted, y, x}
  logic [PW-1:0] pt_mem [MAX_POINTS];
  logic          pt_we;
  logic [IW-1:0] pt_waddr;
  logic [IW-1:0] rd_addr;
  logic [PW-1:0] pt_rdata;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= {cmd.point_deleted, cmd.point_y, cmd.point_x};
    end
    pt_rdata <= pt_mem[rd_addr];
  end

  // nearest-distance memory
  logic [NEAR_W-1:0] nr_mem [MAX_POINTS];
  logic              nr_we;
  logic [IW-1:0]     nr_waddr;
  logic [NEAR_W-1:0] nr_wdata;
  logic [NEAR_W-1:0] nr_rdata;

  always_ff @(posedge clk) begin
    if (nr_we) begin
      nr_mem[nr_waddr] <= nr_wdata;
    end
    nr_rdata <= nr_mem[rd_addr];
  end

  // sequencer registers
  logic                 is_first;
  logic [RAND_W-1:0]    rnd;
  logic [CW-1:0]        cnt;
  logic                 v1, v2, v3;
  logic [IW-1:0]        idx1, idx2, idx3;
  logic [NEAR_W-1:0]    near2, near3;
  logic                 del2, del3;
  logic [NEAR_W-1:0]    sqx, sqy, dist3;
  logic [TW-1:0]        total, cum;
  logic [LO+RAND_W-1:0] p_lo;
  logic [HI+RAND_W-1:0] p_hi;
  logic [TGW-1:0]       target;
  logic                 found;
  logic [IW-1:0]        chosen, first_point;
  logic [COORD_W-1:0]   prev_x, prev_y;
  logic [PCW-1:0]       placed;
  logic                 mod_start, mod_done;
  logic [CW-1:0]        mod_rem;

  kpp_mod_unit #(.DW(RAND_W), .VW(CW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (rnd),
    .divisor  (n_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // datapath helpers
  logic                      issue;
  logic signed [COORD_W:0]   dx, dy;
  logic signed [SQW-1:0]     pdx, pdy;
  logic [NEAR_W-1:0]         nmin;
  logic [TW-1:0]             cum_next;
  logic                      live1;

  always_comb begin
    issue    = (cnt < n_eff);
    dx       = $signed({pt_rdata[COORD_W-1], pt_rdata[COORD_W-1:0]})
             - $signed({prev_x[COORD_W-1], prev_x});
    dy       = $signed({pt_rdata[2*COORD_W-1], pt_rdata[2*COORD_W-1:COORD_W]})
             - $signed({prev_y[COORD_W-1], prev_y});
    pdx      = dx * dx;
    pdy      = dy * dy;
    nmin     = (dist3 < near3) ? dist3 : near3;
    cum_next = cum + TW'(nr_rdata);
    live1    = v1 && !pt_rdata[PW-1] && !found;
  end

  // memory port control
  always_comb begin
    cmd_ready = (state == S_IDLE);
    pt_we     = cmd_valid && cmd_ready && (cmd.kind == KIND_LOAD)
              && (32'(cmd.point_index) < 32'(MAX_POINTS));
    pt_waddr  = IW'(cmd.point_index);
    rd_addr   = ((state == S_FETCH) || (state == S_FETCH2)) ? chosen : cnt[IW-1:0];
    nr_we     = 1'b0;
    nr_waddr  = idx3;
    nr_wdata  = nmin;
    case (state)
      S_CLEAR: begin
        nr_we    = 1'b1;
        nr_waddr = cnt[IW-1:0];
        nr_wdata = (cnt[IW-1:0] == chosen) ? '0 : NEAR_FAR;
      end
      S_P1: begin
        nr_we = v3 && !del3;
      end
      S_FETCH: begin
        nr_we    = !is_first;
        nr_waddr = chosen;
        nr_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  // state machine and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      mod_start   <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      placed      <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
      first_point <= '0;
      found       <= 1'b0;
    end else begin
      mod_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            rnd      <= cmd.random_word;
            is_first <= (cmd.kind == KIND_FIRST);
            res      <= '0;
            if (cmd.kind == KIND_FIRST) begin
              if (n_eff == '0) begin
                res.status <= ST_NO_POINTS;
                res_valid  <= 1'b1;
                state      <= S_DONE;
              end else if (wanted == '0) begin
                res.status <= ST_ALL_DONE;
                res_valid  <= 1'b1;
                state      <= S_DONE;
              end else begin
                mod_start <= 1'b1;
                state     <= S_MOD;
              end
            end else if (cmd.kind == KIND_NEXT) begin
              if ((n_eff == '0) || (placed == '0)) begin
                res.status <= ST_NO_POINTS;
                res_valid  <= 1'b1;
                state      <= S_DONE;
              end else if (placed >= wanted) begin
                res.status <= ST_ALL_DONE;
                res_valid  <= 1'b1;
                state      <= S_DONE;
              end else begin
                cnt   <= '0;
                total <= '0;
                v1    <= 1'b0;
                v2    <= 1'b0;
                v3    <= 1'b0;
                state <= S_P1;
              end
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            chosen <= IW'(mod_rem);
            cnt    <= '0;
            state  <= S_CLEAR;
          end
        end
        // write every nearest entry: far, the first center zero
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(MAX_POINTS - 1)) begin
            state <= S_FETCH;
          end
        end
        // distance update pass: read, square, sum, compare and write back
        S_P1: begin
          v1   <= issue;
          idx1 <= cnt[IW-1:0];
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          v2    <= v1;
          idx2  <= idx1;
          near2 <= nr_rdata;
          del2  <= pt_rdata[PW-1];
          sqx   <= NEAR_W'(pdx);
          sqy   <= NEAR_W'(pdy);
          v3    <= v2;
          idx3  <= idx2;
          near3 <= near2;
          del3  <= del2;
          dist3 <= sqx + sqy;
          if (v3 && !del3) begin
            total <= total + TW'(nmin);
          end
          if (!issue && !v1 && !v2 && !v3) begin
            state <= S_MUL0;
          end
        end
        // target = fraction * total, in two partial products
        S_MUL0: begin
          p_lo  <= {{LO{1'b0}}, rnd} * {{RAND_W{1'b0}}, total[LO-1:0]};
          state <= S_MUL1;
        end
        S_MUL1: begin
          p_hi  <= {{HI{1'b0}}, rnd} * {{RAND_W{1'b0}}, total[TW-1:LO]};
          state <= S_MUL2;
        end
        S_MUL2: begin
          target <= TGW'(p_lo) + {p_hi, {LO{1'b0}}};
          cnt    <= '0;
          cum    <= '0;
          found  <= 1'b0;
          chosen <= first_point;
          v1     <= 1'b0;
          state  <= S_P2;
        end
        // selection pass: running sum against the target
        S_P2: begin
          v1   <= issue;
          idx1 <= cnt[IW-1:0];
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (live1) begin
            cum <= cum_next;
            if ({cum_next, {RAND_W{1'b0}}} >= target) begin
              found  <= 1'b1;
              chosen <= idx1;
            end
          end
          if (!issue && !v1) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_FETCH2;
        end
        S_FETCH2: begin
          prev_x           <= pt_rdata[COORD_W-1:0];
          prev_y           <= pt_rdata[2*COORD_W-1:COORD_W];
          res.center_x     <= pt_rdata[COORD_W-1:0];
          res.center_y     <= pt_rdata[2*COORD_W-1:COORD_W];
          res.chosen_point <= INDEX_W'(chosen);
          res.status       <= ST_PLACED;
          if (is_first) begin
            res.center_slot <= '0;
            placed          <= PCW'(1);
            first_point     <= chosen;
          end else begin
            res.center_slot <= SLOT_W'(placed);
            placed          <= placed + 1'b1;
          end
          res_valid <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
